/* design/ptme_pkg.sv */
// Package for the page table map engine: widths, register selects and walker states.
// No dependencies; the top level and the checker import it.
`default_nettype none

package ptme_pkg;

  localparam int ADDR_W     = 52;
  localparam int LIN_W      = 57;
  localparam int ENTRY_W    = 64;
  localparam int PAGE_SHIFT = 12;
  localparam int IDX_W      = 9;
  localparam int TBL_W      = ADDR_W - PAGE_SHIFT;
  localparam int PADDR_W    = 5;
  localparam int PDATA_W    = 64;
  localparam int REG_LSB    = 3;
  localparam int PDE_LEVEL  = 1;

  typedef logic [1:0] reg_sel_t;

  localparam reg_sel_t REG_ROOT    = 2'd0;
  localparam reg_sel_t REG_FLOOR   = 2'd1;
  localparam reg_sel_t REG_NONLEAF = 2'd2;
  localparam reg_sel_t REG_KEYHOLE = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_READ,
    ST_CHECK,
    ST_LEAF,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

/* design/ptme_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module ptme_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/page_table_map_engine.sv */
// Top level of the page table map engine: config registers, walk sequencer, table store.
// Depends on ptme_pkg and ptme_ram.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one page mapping per transaction:
//   phys_addr, lin_addr, leaf_attributes, keyhole. Output channel
//   (out_valid/out_ready) returns one result per input: out_of_memory and
//   leaf_table_addr (zero when out_of_memory is set).
//   Registers are written through the APB port at byte address 8*i. The user
//   must write them only while the block is idle; the block does not enforce
//   this. pready is always high and reads return the stored value. For each
//   non-leaf level an item takes an address step, a table store read and a
//   check/write-back, then an address step for the leaf level, the leaf write
//   and the result hand-off. A pool failure ends the walk early.
//   One item is in the walk at a time; the output register lets the next
//   item be accepted while a result waits. If the receiver stalls, the walk
//   holds in its final step until the output register frees.
//   After reset the table store is swept to zero, one entry per cycle, through
//   all MAX_TABLES*512 entries; in_ready stays low during the sweep while register
//   writes are taken as usual.
`default_nettype none

module page_table_map_engine import ptme_pkg::*; #(
  parameter int LEVELS     = 4,
  parameter int MAX_TABLES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [ADDR_W-1:0]  phys_addr,
  input  wire logic [LIN_W-1:0]   lin_addr,
  input  wire logic [ENTRY_W-1:0] leaf_attributes,
  input  wire logic               keyhole,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_of_memory,
  output logic      [ADDR_W-1:0]  leaf_table_addr
);

  localparam int DEPTH = MAX_TABLES * (1 << IDX_W);
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(MAX_TABLES);
  localparam int NW    = $clog2(MAX_TABLES + 1);
  localparam int LW    = $clog2(LEVELS);

  state_t state, state_next;

  logic [ADDR_W-1:0]  root_base;
  logic [ADDR_W-1:0]  pool_floor;
  logic [ENTRY_W-1:0] nl_attr;
  logic [ENTRY_W-1:0] kh_attr;

  logic [AW-1:0]      clr_cnt;
  logic [NW-1:0]      next_idx;
  logic [LW-1:0]      lvl;
  logic [TBL_W-1:0]   tbl;
  logic [LIN_W-1:0]   la_q;
  logic [ADDR_W-1:0]  pa_q;
  logic [ENTRY_W-1:0] attr_q;
  logic               kh_q;
  logic [PW-1:0]      page_q;
  logic               backed_q;
  logic               fail_q;
  logic [TBL_W-1:0]   alloc_q;
  logic               res_oom;

  logic [TBL_W-1:0]   rhi;
  logic [TBL_W-1:0]   pg_dist;
  logic [TBL_W-1:0]   nidx_ext;
  logic [TBL_W-1:0]   alloc_c;
  logic               backed_c;
  logic               fail_c;
  logic [IDX_W-1:0]   idx_c;
  logic [ENTRY_W-1:0] entry_c;
  logic               entry_zero;
  logic [ENTRY_W-1:0] new_entry;
  logic               out_free;
  logic               wr_cfg;
  reg_sel_t           sel;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  ptme_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration port
  assign pready = 1'b1;
  assign sel    = paddr[REG_LSB +: 2];
  assign wr_cfg = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_base  <= '0;
      pool_floor <= '0;
      nl_attr    <= '0;
      kh_attr    <= '0;
    end else if (wr_cfg) begin
      case (sel)
        REG_ROOT:    root_base  <= pwdata[ADDR_W-1:0];
        REG_FLOOR:   pool_floor <= pwdata[ADDR_W-1:0];
        REG_NONLEAF: nl_attr    <= pwdata;
        REG_KEYHOLE: kh_attr    <= pwdata;
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_ROOT:    prdata = {{(PDATA_W-ADDR_W){1'b0}}, root_base};
      REG_FLOOR:   prdata = {{(PDATA_W-ADDR_W){1'b0}}, pool_floor};
      REG_NONLEAF: prdata = nl_attr;
      REG_KEYHOLE: prdata = kh_attr;
      default:     prdata = '0;
    endcase
  end

  // address and pool arithmetic
  assign rhi      = root_base[ADDR_W-1:PAGE_SHIFT];
  assign pg_dist  = rhi - tbl;
  assign backed_c = (tbl <= rhi) && (pg_dist < TBL_W'(MAX_TABLES));
  assign nidx_ext = TBL_W'(next_idx);
  assign alloc_c  = rhi - nidx_ext;
  assign fail_c   = (next_idx >= NW'(MAX_TABLES)) || (nidx_ext > rhi) ||
                    ({alloc_c, {PAGE_SHIFT{1'b0}}} < pool_floor);

  always_comb begin
    idx_c = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (lvl == LW'(l)) begin
        idx_c = la_q[PAGE_SHIFT + IDX_W*l +: IDX_W];
      end
    end
  end

  assign entry_c    = backed_q ? ram_rdata : '0;
  assign entry_zero = (entry_c == '0);
  assign new_entry  = {{(ENTRY_W-ADDR_W){1'b0}}, alloc_q, {PAGE_SHIFT{1'b0}}} |
                      ((kh_q && (lvl == LW'(PDE_LEVEL))) ? kh_attr : nl_attr);
  assign out_free   = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_cnt == AW'(DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid) state_next = ST_ADDR;
      ST_ADDR:  state_next = (lvl == '0) ? ST_LEAF : ST_READ;
      ST_READ:  state_next = ST_CHECK;
      ST_CHECK: state_next = (entry_zero && fail_q) ? ST_DONE : ST_ADDR;
      ST_LEAF:  state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // store port and handshake outputs
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = {page_q, idx_c};
    ram_wdata = new_entry;
    ram_re    = 1'b0;
    ram_raddr = {page_q, idx_c};
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
      end
      ST_IDLE:  in_ready = 1'b1;
      ST_READ:  ram_re = backed_q;
      ST_CHECK: ram_we = backed_q && entry_zero && !fail_q;
      ST_LEAF: begin
        ram_we    = backed_q;
        ram_wdata = {{(ENTRY_W-ADDR_W){1'b0}}, pa_q} | attr_q;
      end
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      next_idx  <= NW'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == ST_CHECK && entry_zero && !fail_q) begin
        next_idx <= next_idx + 1'b1;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        la_q    <= lin_addr;
        pa_q    <= phys_addr;
        attr_q  <= leaf_attributes;
        kh_q    <= keyhole;
        tbl     <= rhi;
        lvl     <= LW'(LEVELS - 1);
        res_oom <= 1'b0;
      end
      ST_ADDR: begin
        page_q   <= pg_dist[PW-1:0];
        backed_q <= backed_c;
        fail_q   <= fail_c;
        alloc_q  <= alloc_c;
      end
      ST_CHECK: begin
        if (entry_zero) begin
          if (fail_q) begin
            res_oom <= 1'b1;
          end else begin
            tbl <= new_entry[ADDR_W-1:PAGE_SHIFT];
            lvl <= lvl - 1'b1;
          end
        end else begin
          tbl <= entry_c[ADDR_W-1:PAGE_SHIFT];
          lvl <= lvl - 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_of_memory   <= res_oom;
          leaf_table_addr <= res_oom ? '0 : {tbl, {PAGE_SHIFT{1'b0}}};
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* design/ptme_checker.sv */
// Port-level checker for the page table map engine, bound to the top level.
// Depends on ptme_pkg.
`default_nettype none

module ptme_checker import ptme_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              out_of_memory,
  input wire logic [ADDR_W-1:0] leaf_table_addr
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_of_memory) &&
    $stable(leaf_table_addr))
    else $error("result changed while stalled");

  a_oom_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_memory |-> leaf_table_addr == '0)
    else $error("failed mapping reports a table address");

  a_aligned: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> leaf_table_addr[PAGE_SHIFT-1:0] == '0)
    else $error("leaf table address not page aligned");

  a_one_walk: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted during a walk");

endmodule

bind page_table_map_engine ptme_checker u_ptme_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_of_memory   (out_of_memory),
  .leaf_table_addr (leaf_table_addr)
);

`default_nettype wire
